/* hdl/can_frame_byte_deframer_core_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef CAN_FRAME_BYTE_DEFRAMER_CORE_ASSERT_SVH
`define CAN_FRAME_BYTE_DEFRAMER_CORE_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define CFBD_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("deframer assertion failed");

// Check that cond implies prop in the next cycle.
`define CFBD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("deframer assertion failed");

`endif

/* hdl/cfbd_pkg.sv */
// Package with constants and types for the CAN frame byte deframer.
package cfbd_pkg;

   localparam int unsigned FRAME_DATA_BYTES = 8;
   localparam logic [3:0] MAX_DATA_BYTES = 4'd8;

   localparam logic [7:0] START_BYTE = 8'hFD;
   localparam logic [7:0] END_BYTE   = 8'hBF;

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_ID_LOW = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_END    = 3'd4;

   typedef struct packed {
      logic [11:0] frame_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_data;
   } frame_type;

endpackage

/* hdl/can_frame_byte_deframer_core.sv */
// CAN frame byte deframer: one byte per request in, one frame per good end byte out.
// The block takes one byte per cycle while req_stall is low. A request is held in an
// input register and decoded there while the skid register is empty. Results go to an output
// register backed by a one-entry skid register; req_stall rises only while the input register
// holds a byte and the skid register is full, so input keeps flowing at one byte per cycle as
// long as the result side takes frames. Bytes outside a frame, oversized headers and frames
// with a wrong end byte yield nothing; unused data bytes of a frame read as zero.
module can_frame_byte_deframer_core
   import cfbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_frame_id,
   output logic [3:0]  rsp_frame_length,
   output logic [63:0] rsp_frame_data
);

`include "can_frame_byte_deframer_core_assert.svh"

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bytes_left_ff, bytes_left_in;
   logic [11:0] held_id_ff, held_id_in;
   logic [3:0]  held_length_ff, held_length_in;
   logic [63:0] held_data_ff, held_data_in;
   logic        out_valid_ff, out_valid_in;
   frame_type   out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   frame_type   skid_ff, skid_in;

   logic        proc_go;
   logic        produce;
   logic        pop;
   frame_type   new_frame;

   assign proc_go   = in_valid_ff && !skid_valid_ff;
   assign req_stall = in_valid_ff && skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
   end

   always_comb begin
      logic [3:0] lane_diff;
      logic [2:0] lane_idx;
      lane_diff      = held_length_ff - bytes_left_ff;
      lane_idx       = lane_diff[2:0];
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      held_id_in     = held_id_ff;
      held_length_in = held_length_ff;
      held_data_in   = held_data_ff;
      produce        = 1'b0;
      if (proc_go) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (in_byte_ff[7:4] > MAX_DATA_BYTES) begin
                  phase_in = PH_HUNT;
               end else begin
                  held_length_in = in_byte_ff[7:4];
                  held_id_in     = {in_byte_ff[3:0], 8'h00};
                  phase_in       = PH_ID_LOW;
               end
            end
            PH_ID_LOW: begin
               held_id_in = {held_id_ff[11:8], held_id_ff[7:0] | in_byte_ff};
               if (held_length_ff == 4'd0) begin
                  phase_in = PH_END;
               end else begin
                  bytes_left_in = held_length_ff;
                  phase_in      = PH_DATA;
               end
            end
            PH_DATA: begin
               for (int k = 0; k < FRAME_DATA_BYTES; k++) begin
                  if (lane_idx == 3'(k)) begin
                     held_data_in[8*k +: 8] = held_data_ff[8*k +: 8] | in_byte_ff;
                  end
               end
               bytes_left_in = bytes_left_ff - 4'd1;
               if (bytes_left_ff == 4'd1) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               produce  = (in_byte_ff == END_BYTE);
               phase_in = PH_HUNT;
            end
            default: begin
               if (in_byte_ff == START_BYTE) begin
                  held_id_in     = 12'd0;
                  held_length_in = 4'd0;
                  held_data_in   = 64'd0;
                  bytes_left_in  = 4'd0;
                  phase_in       = PH_HEADER;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   assign new_frame.frame_id     = held_id_ff;
   assign new_frame.frame_length = held_length_ff;
   assign new_frame.frame_data   = held_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff) begin
         out_valid_in = produce;
         out_in       = new_frame;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = produce;
            skid_in       = new_frame;
         end else begin
            out_valid_in = produce;
            out_in       = new_frame;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = new_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_HUNT;
         bytes_left_ff  <= 4'd0;
         held_id_ff     <= 12'd0;
         held_length_ff <= 4'd0;
         held_data_ff   <= 64'd0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         held_id_ff     <= held_id_in;
         held_length_ff <= held_length_in;
         held_data_ff   <= held_data_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
      skid_ff    <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_id     = out_ff.frame_id;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_frame_data   = out_ff.frame_data;

   `CFBD_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CFBD_ASSERT_NEXT(a_blocked_result_to_skid, clock, reset,
      produce && out_valid_ff && rsp_stall, skid_valid_ff)
   `CFBD_ASSERT_IMPLIES(a_header_no_count, clock, reset,
      phase_ff == PH_HEADER, bytes_left_ff == 4'd0)
   `CFBD_ASSERT_IMPLIES(a_data_count_range, clock, reset, phase_ff == PH_DATA,
      bytes_left_ff != 4'd0 && bytes_left_ff <= held_length_ff)

endmodule

/* tb/can_frame_byte_deframer_core_checker.sv */
// Checker that predicts recovered CAN frames from accepted byte requests and compares results.
module can_frame_byte_deframer_core_checker
   import cfbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_frame_id,
   input  logic [3:0]  rsp_frame_length,
   input  logic [63:0] rsp_frame_data,
   output int          mismatch_count,
   output int          frames_pending,
   output int          frames_compared
);

   logic [2:0]  phase;
   logic [3:0]  bytes_left;
   logic [11:0] held_id;
   logic [3:0]  held_length;
   logic [63:0] held_data;

   frame_type   frames_due[$];

   task automatic deframe_byte(input logic [7:0] rx, output bit done, output frame_type frame);
      logic [3:0] len;
      logic [2:0] slot;
      done = 1'b0;
      frame = '0;
      len = rx[7:4];
      slot = 3'(held_length - bytes_left);
      case (phase)
         PH_HEADER: begin
            if (len > MAX_DATA_BYTES) begin
               phase = PH_HUNT;
            end else begin
               held_length = len;
               held_id = {rx[3:0], 8'h00};
               phase = PH_ID_LOW;
            end
         end
         PH_ID_LOW: begin
            held_id = held_id | {4'h0, rx};
            if (held_length == 4'd0) begin
               phase = PH_END;
            end else begin
               bytes_left = held_length;
               phase = PH_DATA;
            end
         end
         PH_DATA: begin
            held_data = held_data | (64'(rx) << {slot, 3'b000});
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) begin
               phase = PH_END;
            end
         end
         PH_END: begin
            if (rx == END_BYTE) begin
               done = 1'b1;
               frame.frame_id = held_id;
               frame.frame_length = held_length;
               frame.frame_data = held_data;
            end
            phase = PH_HUNT;
         end
         default: begin
            if (rx == START_BYTE) begin
               held_id = '0;
               held_length = '0;
               held_data = '0;
               bytes_left = '0;
               phase = PH_HEADER;
            end else begin
               phase = PH_HUNT;
            end
         end
      endcase
   endtask

   function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch_channels
      frame_type expected;
      frame_type predicted;
      bit        produced;
      int        bad;
      if (reset) begin
         phase = PH_HUNT;
         bytes_left = '0;
         held_id = '0;
         held_length = '0;
         held_data = '0;
         frames_due.delete();
         mismatch_count = 0;
         frames_compared = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected frame: expected none, actual id %h length %0d data %h",
                        $time, rsp_frame_id, rsp_frame_length, rsp_frame_data);
            end else begin
               expected = frames_due.pop_front();
               bad = field_differs("frame_id", 64'(expected.frame_id), 64'(rsp_frame_id))
                   + field_differs("frame_length", 64'(expected.frame_length),
                                   64'(rsp_frame_length))
                   + field_differs("frame_data", expected.frame_data, rsp_frame_data);
               if (bad != 0) begin
                  mismatch_count++;
               end
               frames_compared++;
            end
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte, produced, predicted);
            if (produced) begin
               frames_due.push_back(predicted);
            end
         end
      end
      frames_pending = frames_due.size();
   end

endmodule

/* tb/can_frame_byte_deframer_core_tb.sv */
// Testbench top that drives byte requests and result stalls around the deframer and gives the verdict.
module can_frame_byte_deframer_core_tb;
   import cfbd_pkg::*;

   localparam int RANDOM_BYTES = 550;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_frame_id;
   logic [3:0]  rsp_frame_length;
   logic [63:0] rsp_frame_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int mismatch_count;
   int frames_pending;
   int frames_compared;

   can_frame_byte_deframer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_data   (rsp_frame_data)
   );

   can_frame_byte_deframer_core_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_data   (rsp_frame_data),
      .mismatch_count   (mismatch_count),
      .frames_pending   (frames_pending),
      .frames_compared  (frames_compared)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [11:0] id, input logic [3:0] len,
                             input logic [63:0] data, input logic [7:0] end_byte);
      send_byte(START_BYTE);
      send_byte({len, id[11:8]});
      send_byte(id[7:0]);
      for (int k = 0; k < len; k++) begin
         send_byte(data[8*k +: 8]);
      end
      send_byte(end_byte);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (frames_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_traffic(input int byte_budget);
      int stop_at;
      int pick;
      int len;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         len = $urandom_range(8);
         if (pick < 70) begin
            send_frame(12'($urandom), 4'(len), {$urandom, $urandom}, END_BYTE);
         end else if (pick < 78) begin
            send_frame(12'($urandom), 4'(len), {$urandom, $urandom},
                       END_BYTE ^ 8'($urandom_range(1, 255)));
         end else if (pick < 84) begin
            send_byte(START_BYTE);
            send_byte({4'($urandom_range(9, 15)), 4'($urandom)});
         end else if (pick < 90) begin
            send_byte(START_BYTE);
            send_byte({4'(len), 4'($urandom)});
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_byte($urandom_range(1) ? START_BYTE : 8'($urandom));
            end
         end
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'h00);
      send_frame(12'h000, 4'd0, 64'h0, END_BYTE);
      send_frame(12'hFFF, MAX_DATA_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, END_BYTE);
      send_byte(START_BYTE);
      send_byte(8'h9F);
      send_frame(12'h5A3, 4'd1, 64'hAA, START_BYTE);
      drain_frames();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 65;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 65;
            end
            default: begin
               send_idle_pct = 17;
               rsp_stall_pct = 17;
            end
         endcase
         send_random_traffic(RANDOM_BYTES / 4);
         drain_frames();
      end

      $display("Sent %0d bytes under four idle and stall mixes; %0d frames compared.",
               bytes_sent, frames_compared);
      $display("Traffic held empty and full frames, oversized headers, bad end bytes and noise.");
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
